// ----- sv/quad_vertex_trim_core_macros.svh -----
// Assertion macros shared by the quad vertex trim modules.
`ifndef QUAD_VERTEX_TRIM_CORE_MACROS_SVH
`define QUAD_VERTEX_TRIM_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk and off during reset.
`define QVT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, clocked on clk and off during reset.
`define QVT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ----- sv/qvt_pkg.sv -----
// Widths, codes and types shared by the quad vertex trim modules.
package qvt_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;

	// trim fractions: 16 fraction bits, one more bit to hold exactly one
	localparam int TRIM_FRAC = 16;
	localparam int TRIM_W    = TRIM_FRAC + 1;
	localparam logic [TRIM_W-1:0] TRIM_ONE = {1'b1, {TRIM_FRAC{1'b0}}};

	localparam int NUM_REGS  = 4;
	localparam int REG_IDX_W = $clog2(NUM_REGS);
	localparam logic [REG_IDX_W-1:0] REG_LEFT   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_RIGHT  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_TOP    = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_BOTTOM = 2'd3;

	localparam int NUM_CORNERS = 4;
	localparam int IDX_W       = 2;
	localparam logic [IDX_W-1:0] IDX_LAST = 2'd3;

	localparam int SUMW  = COORD_WIDTH + 2;          // sum of four corners
	localparam int AXW   = COORD_WIDTH + 3;          // axis and offset vectors
	localparam int NW    = 2 * AXW;                  // squared axis length
	localparam int RADW  = NW + 2 * FRAC_BITS;       // square root radicand
	localparam int LENW  = RADW / 2;                 // scaled axis length
	localparam int UW    = FRAC_BITS + 3;            // signed unit component
	localparam int DNW   = AXW + 2 * FRAC_BITS;      // unit division numerator
	localparam int MA    = AXW + UW;                 // multiplicand width
	localparam int MB    = AXW;                      // multiplier width
	localparam int ACCW  = MA + MB + 1;              // accumulator width
	localparam int ADW   = ACCW + 1;                 // shared adder width
	localparam int RMW   = LENW + 2;                 // partial remainder
	localparam int ARGW  = (NW > DNW) ? NW : DNW;
	localparam int ARGBW = LENW;
	localparam int CNT_W = $clog2(DNW + LENW + MB);

	localparam logic [COORD_WIDTH-1:0] PIX_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic [COORD_WIDTH-1:0] PIX_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	typedef enum logic [1:0] {
		OP_MUL  = 2'd0,
		OP_SQRT = 2'd1,
		OP_DIV  = 2'd2
	} qvt_op_t;

	typedef struct packed {
		logic    start;
		qvt_op_t op;
		logic    neg;
	} qvt_req_t;

endpackage

// ----- sv/quad_vertex_trim_core.sv -----
// Quad vertex trim: collects four corners, emits the four corners, trimmed or passed through unchanged.
// Corners are taken while idle; corner 3 starts the trim work, during which input stalls.
// The bit-serial shared unit computes one multiply, root or quotient bit per cycle.
// Results then leave one per handshake.
// Reset clears the sequencer, handshakes and trim registers; corner stores stay unset.
`include "quad_vertex_trim_core_macros.svh"

module quad_vertex_trim_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic [qvt_pkg::REG_IDX_W-1:0]          cfg_index,
	input  logic [qvt_pkg::TRIM_W-1:0]             cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [qvt_pkg::IDX_W-1:0]              corner_index,
	input  logic signed [qvt_pkg::COORD_WIDTH-1:0] corner_x,
	input  logic signed [qvt_pkg::COORD_WIDTH-1:0] corner_y,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [qvt_pkg::IDX_W-1:0]              out_index,
	output logic signed [qvt_pkg::COORD_WIDTH-1:0] out_x,
	output logic signed [qvt_pkg::COORD_WIDTH-1:0] out_y,
	output logic                                   degenerate,
	output logic                                   last_corner
);
	import qvt_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam logic [IDX_W-1:0] EDGE_A [NUM_CORNERS] = '{2'd0, 2'd2, 2'd0, 2'd1};
	localparam logic [IDX_W-1:0] EDGE_B [NUM_CORNERS] = '{2'd1, 2'd3, 2'd3, 2'd2};

	typedef enum logic [3:0] {
		S_IDLE, S_AXES, S_NX, S_NY, S_SQRT, S_UX, S_UY, S_CORNER,
		S_PX, S_PY, S_SCL, S_OFX, S_OFY, S_FIN, S_PASS, S_OUT
	} state_t;

	state_t               state_q;
	logic                 pend_q;
	logic                 degen_q;
	logic [IDX_W-1:0]     k_q;
	logic [IDX_W-1:0]     i_q;
	logic                 cnt_q;
	logic [TRIM_W-1:0]    trim_q [NUM_REGS];

	logic signed [CW-1:0]   stx_q [NUM_CORNERS];
	logic signed [CW-1:0]   sty_q [NUM_CORNERS];
	logic signed [SUMW-1:0] sx_q, sy_q;
	logic signed [AXW-1:0]  ax_q [NUM_CORNERS];
	logic signed [AXW-1:0]  ay_q [NUM_CORNERS];
	logic signed [AXW-1:0]  dx_q [NUM_CORNERS];
	logic signed [AXW-1:0]  dy_q [NUM_CORNERS];
	logic signed [UW-1:0]   ux_q [NUM_CORNERS];
	logic signed [UW-1:0]   uy_q [NUM_CORNERS];
	logic [LENW-1:0]        len_q;
	logic [MA-1:0]          p_q;
	logic [MA-1:0]          s_q;
	logic signed [ACCW-1:0] offx_q, offy_q;

	logic signed [SUMW-1:0] sx_c, sy_c;
	logic signed [AXW-1:0]  ax_c [NUM_CORNERS];
	logic signed [AXW-1:0]  ay_c [NUM_CORNERS];
	logic signed [AXW-1:0]  dx_c [NUM_CORNERS];
	logic signed [AXW-1:0]  dy_c [NUM_CORNERS];
	logic                   degen_c;

	logic [TRIM_W-1:0]      trim_sel;
	logic [TRIM_W-1:0]      f_c;
	logic [ACCW-1:0]        term_mag;
	logic signed [ACCW-1:0] term_x, term_y;
	logic signed [ACCW-1:0] rx_c, ry_c;

	qvt_req_t               u_req;
	logic                   op_state;
	logic [ARGW-1:0]        u_arg_a;
	logic [ARGBW-1:0]       u_arg_b;
	logic [ACCW-1:0]        u_acc_init;
	logic [ACCW-1:0]        u_res;
	logic                   u_done;
	logic                   step_done;

	function automatic logic [AXW-1:0] mag_ax(input logic signed [AXW-1:0] v);
		return v[AXW-1] ? AXW'(-v) : AXW'(v);
	endfunction

	function automatic logic [UW-1:0] mag_u(input logic signed [UW-1:0] v);
		return v[UW-1] ? UW'(-v) : UW'(v);
	endfunction

	// round half up at quarter-pixel scale, then clamp to the coordinate range
	function automatic logic [CW-1:0] to_pixel(input logic signed [ACCW-1:0] r);
		logic signed [ACCW-1:0] v;
		logic [ACCW-CW:0]       top;
		v   = (r + $signed(ACCW'(1) << (FRAC_BITS + 1))) >>> (FRAC_BITS + 2);
		top = v[ACCW-1:CW-1];
		if ((&top) || !(|top))
			return v[CW-1:0];
		return v[ACCW-1] ? PIX_MIN : PIX_MAX;
	endfunction

	// centroid sums, axes and corner offsets in quarter pixels
	always_comb begin
		sx_c    = SUMW'(stx_q[0]) + SUMW'(stx_q[1]) + SUMW'(stx_q[2]) + SUMW'(stx_q[3]);
		sy_c    = SUMW'(sty_q[0]) + SUMW'(sty_q[1]) + SUMW'(sty_q[2]) + SUMW'(sty_q[3]);
		degen_c = 1'b0;
		for (int k = 0; k < NUM_CORNERS; k++) begin
			ax_c[k] = ((AXW'(stx_q[EDGE_A[k]]) + AXW'(stx_q[EDGE_B[k]])) <<< 1) - AXW'(sx_c);
			ay_c[k] = ((AXW'(sty_q[EDGE_A[k]]) + AXW'(sty_q[EDGE_B[k]])) <<< 1) - AXW'(sy_c);
			dx_c[k] = (AXW'(stx_q[k]) <<< 2) - AXW'(sx_c);
			dy_c[k] = (AXW'(sty_q[k]) <<< 2) - AXW'(sy_c);
			if (ax_c[k] == '0 && ay_c[k] == '0)
				degen_c = 1'b1;
		end
	end

	// axis order is top, bottom, left, right
	always_comb begin
		case (k_q)
			2'd0:    trim_sel = trim_q[REG_TOP];
			2'd1:    trim_sel = trim_q[REG_BOTTOM];
			2'd2:    trim_sel = trim_q[REG_LEFT];
			2'd3:    trim_sel = trim_q[REG_RIGHT];
			default: trim_sel = '0;
		endcase
		f_c      = trim_sel[TRIM_W-1] ? '0 : TRIM_ONE - trim_sel;
		term_mag = u_res >> FRAC_BITS;
		term_x   = ux_q[k_q][UW-1] ? -$signed(term_mag) : $signed(term_mag);
		term_y   = uy_q[k_q][UW-1] ? -$signed(term_mag) : $signed(term_mag);
		rx_c     = (ACCW'(sx_q) <<< FRAC_BITS) + offx_q;
		ry_c     = (ACCW'(sy_q) <<< FRAC_BITS) + offy_q;
	end

	// operands for the shared unit
	always_comb begin
		op_state   = 1'b0;
		u_req      = '0;
		u_arg_a    = '0;
		u_arg_b    = '0;
		u_acc_init = '0;
		case (state_q)
			S_NX: begin
				op_state  = 1'b1;
				u_req.op  = OP_MUL;
				u_arg_a   = ARGW'(mag_ax(ax_q[k_q]));
				u_arg_b   = ARGBW'(mag_ax(ax_q[k_q]));
			end
			S_NY: begin
				op_state   = 1'b1;
				u_req.op   = OP_MUL;
				u_arg_a    = ARGW'(mag_ax(ay_q[k_q]));
				u_arg_b    = ARGBW'(mag_ax(ay_q[k_q]));
				u_acc_init = u_res;
			end
			S_SQRT: begin
				op_state = 1'b1;
				u_req.op = OP_SQRT;
				u_arg_a  = ARGW'(u_res[NW-1:0]);
			end
			S_UX: begin
				op_state = 1'b1;
				u_req.op = OP_DIV;
				u_arg_a  = ARGW'((DNW'(mag_ax(ax_q[k_q])) << (2 * FRAC_BITS))
				           + DNW'(len_q >> 1));
				u_arg_b  = ARGBW'(len_q);
			end
			S_UY: begin
				op_state = 1'b1;
				u_req.op = OP_DIV;
				u_arg_a  = ARGW'((DNW'(mag_ax(ay_q[k_q])) << (2 * FRAC_BITS))
				           + DNW'(len_q >> 1));
				u_arg_b  = ARGBW'(len_q);
			end
			S_PX: begin
				op_state  = 1'b1;
				u_req.op  = OP_MUL;
				u_req.neg = dx_q[i_q][AXW-1] ^ ux_q[k_q][UW-1];
				u_arg_a   = ARGW'(mag_ax(dx_q[i_q]));
				u_arg_b   = ARGBW'(mag_u(ux_q[k_q]));
			end
			S_PY: begin
				op_state   = 1'b1;
				u_req.op   = OP_MUL;
				u_req.neg  = dy_q[i_q][AXW-1] ^ uy_q[k_q][UW-1];
				u_arg_a    = ARGW'(mag_ax(dy_q[i_q]));
				u_arg_b    = ARGBW'(mag_u(uy_q[k_q]));
				u_acc_init = u_res;
			end
			S_SCL: begin
				op_state = 1'b1;
				u_req.op = OP_MUL;
				u_arg_a  = ARGW'(p_q);
				u_arg_b  = ARGBW'(f_c);
			end
			S_OFX: begin
				op_state = 1'b1;
				u_req.op = OP_MUL;
				u_arg_a  = ARGW'(s_q);
				u_arg_b  = ARGBW'(mag_u(ux_q[k_q]));
			end
			S_OFY: begin
				op_state = 1'b1;
				u_req.op = OP_MUL;
				u_arg_a  = ARGW'(s_q);
				u_arg_b  = ARGBW'(mag_u(uy_q[k_q]));
			end
			default: op_state = 1'b0;
		endcase
		u_req.start = op_state && !pend_q;
	end

	assign step_done = pend_q && u_done;
	assign in_stall  = (state_q != S_IDLE);

	qvt_iter_unit u_iter (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (u_req),
		.arg_a    (u_arg_a),
		.arg_b    (u_arg_b),
		.acc_init (u_acc_init),
		.res      (u_res),
		.done     (u_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pend_q      <= 1'b0;
			degen_q     <= 1'b0;
			k_q         <= '0;
			i_q         <= '0;
			cnt_q       <= 1'b0;
			for (int r = 0; r < NUM_REGS; r++)
				trim_q[r] <= '0;
			out_valid   <= 1'b0;
			out_index   <= '0;
			out_x       <= '0;
			out_y       <= '0;
			degenerate  <= 1'b0;
			last_corner <= 1'b0;
		end else begin
			if (cfg_wr_en)
				trim_q[cfg_index] <= cfg_data;
			// hold a unit request open until its result comes back
			if (op_state) begin
				if (!pend_q)
					pend_q <= 1'b1;
				else if (u_done)
					pend_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && corner_index == IDX_LAST)
						state_q <= S_AXES;
				end
				S_AXES: begin
					degen_q <= degen_c;
					k_q     <= '0;
					i_q     <= '0;
					state_q <= degen_c ? S_CORNER : S_NX;
				end
				S_NX:   if (step_done) state_q <= S_NY;
				S_NY:   if (step_done) state_q <= S_SQRT;
				S_SQRT: if (step_done) state_q <= S_UX;
				S_UX:   if (step_done) state_q <= S_UY;
				S_UY: begin
					if (step_done) begin
						if (k_q == IDX_LAST) begin
							k_q     <= '0;
							state_q <= S_CORNER;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_NX;
						end
					end
				end
				S_CORNER: begin
					k_q     <= '0;
					cnt_q   <= 1'b0;
					state_q <= degen_q ? S_PASS : S_PX;
				end
				S_PX: if (step_done) state_q <= S_PY;
				S_PY: begin
					if (step_done) begin
						if (!u_res[ACCW-1])
							state_q <= S_SCL;
						else if (k_q == IDX_LAST)
							state_q <= S_PASS;
						else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_PX;
						end
					end
				end
				S_SCL: if (step_done) state_q <= S_OFX;
				S_OFX: if (step_done) state_q <= S_OFY;
				S_OFY: begin
					if (step_done) begin
						if (cnt_q)
							state_q <= S_FIN;
						else if (k_q == IDX_LAST)
							state_q <= S_PASS;
						else begin
							cnt_q   <= 1'b1;
							k_q     <= k_q + 1'b1;
							state_q <= S_PX;
						end
					end
				end
				S_FIN: begin
					out_valid   <= 1'b1;
					out_index   <= i_q;
					out_x       <= to_pixel(rx_c);
					out_y       <= to_pixel(ry_c);
					degenerate  <= degen_q;
					last_corner <= (i_q == IDX_LAST);
					state_q     <= S_OUT;
				end
				S_PASS: begin
					out_valid   <= 1'b1;
					out_index   <= i_q;
					out_x       <= stx_q[i_q];
					out_y       <= sty_q[i_q];
					degenerate  <= degen_q;
					last_corner <= (i_q == IDX_LAST);
					state_q     <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						if (i_q == IDX_LAST)
							state_q <= S_IDLE;
						else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_CORNER;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					stx_q[corner_index] <= corner_x;
					sty_q[corner_index] <= corner_y;
				end
			end
			S_AXES: begin
				sx_q <= sx_c;
				sy_q <= sy_c;
				for (int k = 0; k < NUM_CORNERS; k++) begin
					ax_q[k] <= ax_c[k];
					ay_q[k] <= ay_c[k];
					dx_q[k] <= dx_c[k];
					dy_q[k] <= dy_c[k];
				end
			end
			S_SQRT: if (step_done) len_q <= u_res[LENW-1:0];
			S_UX: begin
				if (step_done)
					ux_q[k_q] <= ax_q[k_q][AXW-1] ? -$signed(UW'(u_res)) : $signed(UW'(u_res));
			end
			S_UY: begin
				if (step_done)
					uy_q[k_q] <= ay_q[k_q][AXW-1] ? -$signed(UW'(u_res)) : $signed(UW'(u_res));
			end
			S_CORNER: begin
				offx_q <= '0;
				offy_q <= '0;
			end
			S_PY:  if (step_done) p_q <= u_res[MA-1:0];
			S_SCL: if (step_done) s_q <= MA'(u_res >> TRIM_FRAC);
			S_OFX: if (step_done) offx_q <= offx_q + term_x;
			S_OFY: if (step_done) offy_q <= offy_q + term_y;
			default: offx_q <= offx_q;
		endcase
	end

	`QVT_ASSERT_IMP(a_ready_no_result, !in_stall, !out_valid)
	`QVT_ASSERT_IMP(a_done_expected, u_done, pend_q)
	`QVT_ASSERT_NXT(a_last_frees_input, out_valid && !out_stall && last_corner, !in_stall)

endmodule

// ----- sv/qvt_iter_unit.sv -----
// Bit-serial shared unit: multiply-accumulate, square root and division.
`include "quad_vertex_trim_core_macros.svh"

module qvt_iter_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  qvt_pkg::qvt_req_t          req,
	input  logic [qvt_pkg::ARGW-1:0]   arg_a,
	input  logic [qvt_pkg::ARGBW-1:0]  arg_b,
	input  logic [qvt_pkg::ACCW-1:0]   acc_init,
	output logic [qvt_pkg::ACCW-1:0]   res,
	output logic                       done
);
	import qvt_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	qvt_op_t          op_q;
	logic             neg_q;
	logic [ACCW-1:0]  acc_q;
	logic [ACCW-1:0]  mcand_q;
	logic [MB-1:0]    mplier_q;
	logic [RADW-1:0]  rad_q;
	logic [RMW-1:0]   rem_q;
	logic [LENW-1:0]  den_q;

	logic [ADW-1:0]   add_a;
	logic [ADW-1:0]   add_b;
	logic [ADW-1:0]   add_sum;
	logic             add_sub;
	logic             ge;

	// one adder serves every step; subtract results are checked by sign
	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_sub = 1'b0;
		case (op_q)
			OP_MUL: begin
				add_a   = {acc_q[ACCW-1], acc_q};
				add_b   = {1'b0, mcand_q};
				add_sub = neg_q;
			end
			OP_SQRT: begin
				add_a   = ADW'({rem_q[RMW-3:0], rad_q[RADW-1 -: 2]});
				add_b   = ADW'({acc_q[LENW-1:0], 2'b01});
				add_sub = 1'b1;
			end
			OP_DIV: begin
				add_a   = ADW'({rem_q[RMW-2:0], rad_q[RADW-1]});
				add_b   = ADW'(den_q);
				add_sub = 1'b1;
			end
			default: begin
				add_a   = '0;
				add_b   = '0;
				add_sub = 1'b0;
			end
		endcase
		add_sum = add_a + (add_sub ? ~add_b : add_b) + ADW'(add_sub);
		ge      = ~add_sum[ADW-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= OP_MUL;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				case (req.op)
					OP_MUL:  cnt_q <= CNT_W'(MB - 1);
					OP_SQRT: cnt_q <= CNT_W'(LENW - 1);
					OP_DIV:  cnt_q <= CNT_W'(DNW - 1);
					default: cnt_q <= '0;
				endcase
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.neg;
			case (req.op)
				OP_MUL: begin
					acc_q    <= acc_init;
					mcand_q  <= ACCW'(arg_a[MA-1:0]);
					mplier_q <= arg_b[MB-1:0];
				end
				OP_SQRT: begin
					acc_q <= '0;
					rem_q <= '0;
					rad_q <= {arg_a[NW-1:0], {(RADW-NW){1'b0}}};
				end
				OP_DIV: begin
					acc_q <= '0;
					rem_q <= '0;
					rad_q <= {arg_a[DNW-1:0], {(RADW-DNW){1'b0}}};
					den_q <= arg_b[LENW-1:0];
				end
				default: acc_q <= '0;
			endcase
		end else if (busy_q) begin
			case (op_q)
				OP_MUL: begin
					if (mplier_q[0])
						acc_q <= add_sum[ACCW-1:0];
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
				end
				OP_SQRT: begin
					rad_q <= rad_q << 2;
					rem_q <= ge ? add_sum[RMW-1:0] : add_a[RMW-1:0];
					acc_q <= {acc_q[ACCW-2:0], ge};
				end
				OP_DIV: begin
					rad_q <= rad_q << 1;
					rem_q <= ge ? add_sum[RMW-1:0] : add_a[RMW-1:0];
					acc_q <= {acc_q[ACCW-2:0], ge};
				end
				default: acc_q <= acc_q;
			endcase
		end
	end

	assign res  = acc_q;
	assign done = done_q;

	`QVT_ASSERT_IMP(a_start_when_idle, req.start, !busy_q)
	`QVT_ASSERT_NXT(a_start_sets_busy, req.start, busy_q)
	`QVT_ASSERT_IMP(a_done_after_busy, done_q, !busy_q)

endmodule
